### rtl/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int OP_W  = 2;
    localparam int IDX_W = 16;
    localparam int ST_W  = 2;
    localparam int CNT_W = 13;

    localparam int TOTAL_RESET = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_FAIL     = 2'd0,
        ST_USED     = 2'd1,
        ST_FREE     = 2'd2,
        ST_WAS_FREE = 2'd3
    } t_status;

endpackage

### rtl/bba_if.sv
`timescale 1ns / 1ps

interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::OP_W-1:0]   opcode;
    logic [bba_pkg::IDX_W-1:0]  block_index;

    modport source (output valid, opcode, block_index, input ready);
    modport sink   (input valid, opcode, block_index, output ready);
endinterface

interface bba_res_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::ST_W-1:0]   status;
    logic [bba_pkg::IDX_W-1:0]  result_block;
    logic [bba_pkg::CNT_W-1:0]  free_count;

    modport source (output valid, status, result_block, free_count, input ready);
    modport sink   (input valid, status, result_block, free_count, output ready);
endinterface

### rtl/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bba_split.sv
`timescale 1ns / 1ps

module bba_split #(
    parameter int WORD_BITS = 32,
    parameter int AW = 7,
    localparam int BW = $clog2(WORD_BITS)
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [bba_pkg::IDX_W-1:0]  i_blk,
    output logic [AW-1:0]              o_word,
    output logic [BW-1:0]              o_bit
);
    import bba_pkg::*;

    localparam int SH    = IDX_W + BW;
    localparam int RECIP = (1 << SH) / WORD_BITS + 1;
    localparam int RW    = SH + 1;
    localparam int PW    = IDX_W + RW;
    localparam int MW    = IDX_W + BW + 1;

    logic [IDX_W-1:0] r_blk;
    logic [IDX_W-1:0] r_q;
    logic [BW-1:0]    r_bit;
    logic [PW-1:0]    w_prod;
    logic [MW-1:0]    w_back;
    logic [IDX_W-1:0] w_rem;

    // quotient by reciprocal, exact for every index value
    assign w_prod = {{RW{1'b0}}, i_blk} * PW'(RECIP);
    assign w_back = {{(BW+1){1'b0}}, r_q} * MW'(WORD_BITS);
    assign w_rem  = r_blk - w_back[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk <= i_blk;
            r_q   <= w_prod[SH +: IDX_W];
        end
        r_bit <= w_rem[BW-1:0];
    end

    assign o_word = r_q[AW-1:0];
    assign o_bit  = r_bit;

endmodule

### rtl/bba_find.sv
`timescale 1ns / 1ps

module bba_find #(
    parameter int WORD_BITS = 32,
    localparam int BW = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] i_bits,
    output logic                 o_found,
    output logic [BW-1:0]        o_pos
);

    // lowest set bit wins
    always_comb begin
        o_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_pos = BW'(i);
            end
        end
        o_found = |i_bits;
    end

endmodule

### rtl/bitmap_block_allocator.sv
`timescale 1ns / 1ps

// Bitmap block allocator: one used bit per block, kept in a word-wide RAM.
// Request channel i_req (valid/ready) carries opcode and block_index; result
// channel o_res (valid/ready) returns status, result_block and free_count, one
// result item for every request item, in order.
// i_cfg_we / i_cfg_data write the total block count; write it only while idle.
// Allocate reads the hint word on acceptance, then one more per full word
// skipped; check and deallocate first register the word/bit split of
// block_index, then read that word. The map stage registers the result into
// o_res once the output register is free; the block is then idle and takes
// the next request. A scan starts at a hint word below which every word is
// known full. One request is in flight at a time; the map RAM read port
// (one word per cycle) bounds the scan rate. After reset a clearing pass
// writes zero to every map word, one per cycle; i_req.ready stays low then.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result holds in the map stage until o_res.ready frees
// the register.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0]  i_cfg_data,
    bba_req_if.sink                    i_req,
    bba_res_if.source                  o_res
);
    import bba_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
    localparam int CW        = (BASE_W > IDX_W) ? BASE_W : IDX_W;
    localparam int CNT_MAX   = (1 << CNT_W) - 1;
    localparam int TOT_CAP   = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_LOOK
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]      r_hint, n_hint;
    logic [BASE_W-1:0]  r_hint_base, n_hint_base;
    logic [AW-1:0]      r_addr, n_addr;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [OP_W-1:0]    r_op, n_op;
    logic [IDX_W-1:0]   r_blk, n_blk;
    logic               r_out_valid, n_out_valid;
    logic [ST_W-1:0]    r_status, n_status;
    logic [IDX_W-1:0]   r_result, n_result;
    logic [CNT_W-1:0]   r_free, n_free;

    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr;
    logic [WORD_BITS-1:0] w_ram_wdata;
    logic                 w_ram_re;
    logic [AW-1:0]        w_ram_raddr;
    logic [WORD_BITS-1:0] w_rdata;

    logic                 w_split_en;
    logic [AW-1:0]        w_word;
    logic [BW-1:0]        w_bit;

    logic [CNT_W-1:0]     w_tot;
    logic                 w_slot;
    logic                 w_in_range;
    logic                 w_cur_bit;
    logic                 w_base_ok;
    logic [CW-1:0]        w_lim;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_avail;
    logic                 w_found;
    logic [BW-1:0]        w_pos;
    logic                 w_full;
    logic [CW-1:0]        w_alloc_idx;

    logic                 w_fin;
    logic                 w_write;
    logic [WORD_BITS-1:0] w_wdata;
    logic [ST_W-1:0]      w_status;
    logic [IDX_W-1:0]     w_result;
    logic [CNT_W-1:0]     w_cnt_new;
    logic                 w_lower_hint;
    logic                 w_advance;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    bba_split #(
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_split (
        .i_clk  (i_clk),
        .i_en   (w_split_en),
        .i_blk  (i_req.block_index),
        .o_word (w_word),
        .o_bit  (w_bit)
    );

    bba_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .i_bits  (w_avail),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign w_tot  = (r_total > CNT_W'(TOT_CAP)) ? CNT_W'(TOT_CAP) : r_total;
    assign w_slot = !r_out_valid || o_res.ready;

    // map word evaluation
    always_comb begin
        w_in_range  = r_blk < IDX_W'(w_tot);
        w_cur_bit   = w_rdata[w_bit];
        w_base_ok   = CW'(r_base) < CW'(w_tot);
        w_lim       = CW'(w_tot) - CW'(r_base);
        for (int i = 0; i < WORD_BITS; i++) begin
            w_mask[i] = CW'(i) < w_lim;
        end
        w_avail     = ~w_rdata & w_mask;
        w_full      = &w_rdata;
        w_alloc_idx = CW'(r_base) + CW'(w_pos);
    end

    // per-opcode outcome in the map stage
    always_comb begin
        w_fin        = 1'b0;
        w_write      = 1'b0;
        w_wdata      = w_rdata;
        w_status     = ST_FAIL;
        w_result     = r_blk;
        w_cnt_new    = r_cnt;
        w_lower_hint = 1'b0;
        w_advance    = 1'b0;
        case (r_op)
            OP_CHECK: begin
                w_fin = 1'b1;
                if (w_in_range) begin
                    w_status = w_cur_bit ? ST_USED : ST_FREE;
                end
            end
            OP_FREE: begin
                w_fin = 1'b1;
                if (w_in_range && w_cur_bit) begin
                    w_write      = 1'b1;
                    w_wdata      = w_rdata & ~(WORD_BITS'(1) << w_bit);
                    w_status     = ST_FREE;
                    w_cnt_new    = (r_cnt != '0) ? r_cnt - CNT_W'(1) : r_cnt;
                    w_lower_hint = r_addr < r_hint;
                end else if (w_in_range) begin
                    w_status = ST_WAS_FREE;
                end
            end
            OP_ALLOC: begin
                w_result = '0;
                if (w_base_ok && w_found) begin
                    w_fin     = 1'b1;
                    w_write   = 1'b1;
                    w_wdata   = w_rdata | (WORD_BITS'(1) << w_pos);
                    w_status  = ST_USED;
                    w_result  = w_alloc_idx[IDX_W-1:0];
                    w_cnt_new = r_cnt + CNT_W'(1);
                end else if (w_base_ok && w_full && (r_addr != LAST_WORD)) begin
                    w_advance = 1'b1;
                end else begin
                    w_fin = 1'b1;
                end
            end
            default: begin
                w_fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_total     = i_cfg_we ? i_cfg_data : r_total;
        n_cnt       = r_cnt;
        n_hint      = r_hint;
        n_hint_base = r_hint_base;
        n_addr      = r_addr;
        n_base      = r_base;
        n_op        = r_op;
        n_blk       = r_blk;
        n_out_valid = (r_out_valid && o_res.ready) ? 1'b0 : r_out_valid;
        n_status    = r_status;
        n_result    = r_result;
        n_free      = r_free;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_wdata = w_wdata;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_addr;
        w_split_en  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = '0;
                if (r_addr == LAST_WORD) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.opcode;
                    n_blk      = i_req.block_index;
                    w_split_en = 1'b1;
                    if (i_req.opcode == OP_ALLOC) begin
                        w_ram_re    = 1'b1;
                        w_ram_raddr = r_hint;
                        n_addr      = r_hint;
                        n_base      = r_hint_base;
                        n_state     = S_LOOK;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_word;
                n_addr      = w_word;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                if (w_advance) begin
                    // word full, move the scan and the hint on together
                    w_ram_re    = 1'b1;
                    w_ram_raddr = r_addr + AW'(1);
                    n_addr      = r_addr + AW'(1);
                    n_base      = r_base + BASE_W'(WORD_BITS);
                    n_hint      = r_addr + AW'(1);
                    n_hint_base = r_base + BASE_W'(WORD_BITS);
                end else if (w_fin && w_slot) begin
                    w_ram_we    = w_write;
                    n_cnt       = w_cnt_new;
                    n_out_valid = 1'b1;
                    n_status    = w_status;
                    n_result    = w_result;
                    n_free      = (w_tot > w_cnt_new) ? w_tot - w_cnt_new : '0;
                    n_state     = S_IDLE;
                    if (w_lower_hint) begin
                        n_hint      = r_addr;
                        n_hint_base = BASE_W'(r_blk - IDX_W'(w_bit));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_total     <= CNT_W'(TOTAL_RESET);
            r_cnt       <= '0;
            r_hint      <= '0;
            r_hint_base <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_cnt       <= n_cnt;
            r_hint      <= n_hint;
            r_hint_base <= n_hint_base;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
        r_base   <= n_base;
        r_op     <= n_op;
        r_blk    <= n_blk;
        r_status <= n_status;
        r_result <= n_result;
        r_free   <= n_free;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.result_block = r_result;
    assign o_res.free_count   = r_free;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("map write and read in the same cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hint_base == BASE_W'(r_hint) * BASE_W'(WORD_BITS))
        else $error("hint base out of step with hint word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt == $past(r_cnt)) ||
            (r_cnt == $past(r_cnt) + CNT_W'(1)) ||
            (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("allocated count moved by more than one");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (w_ram_we && (w_ram_wdata == '0) && !i_req.ready))
        else $error("clearing pass not writing zero words");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_cnt))
        else $error("count changed while result register was blocked");

endmodule
